// File: rtl/core/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants of the bitmap slot allocator: request and
// response codes, sequencer states and the map word geometry.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // map word geometry: one memory word holds 64 slots
    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;

    // field widths
    localparam int SIZE_W   = 13;
    localparam int SLOT_W   = 12;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;

    // slot count after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    // request actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_MARK   = 2'd1,
        ACT_UNMARK = 2'd2,
        ACT_TEST   = 2'd3
    } action_t;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_RANGE   = 3'd2,
        ST_ISSET   = 3'd3,
        ST_ISCLEAR = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EVAL  = 2'd2
    } state_t;

endpackage

// File: rtl/core/bsa_req_if.sv
// ----------------------------------------------------------------------------
// bsa_req_if
// Request channel of the allocator: action and slot index.
// ----------------------------------------------------------------------------
interface bsa_req_if;
    logic                        valid;
    logic                        ready;
    bsa_pkg::action_t            action;
    logic [bsa_pkg::SLOT_W-1:0]  slot_index;

    modport source (output valid, output action, output slot_index, input ready);
    modport sink   (input valid, input action, input slot_index, output ready);
endinterface

// File: rtl/core/bsa_rsp_if.sv
// ----------------------------------------------------------------------------
// bsa_rsp_if
// Response channel of the allocator: status, handed out slot and test value.
// ----------------------------------------------------------------------------
interface bsa_rsp_if;
    logic                        valid;
    logic                        ready;
    bsa_pkg::status_t            status;
    logic [bsa_pkg::SLOT_W-1:0]  result_index;
    logic                        bit_value;

    modport source (output valid, output status, output result_index, output bit_value,
                    input ready);
    modport sink   (input valid, input status, input result_index, input bit_value,
                    output ready);
endinterface

// File: rtl/core/bsa_cfg_if.sv
// ----------------------------------------------------------------------------
// bsa_cfg_if
// Configuration write channel: number of slots in use.
// ----------------------------------------------------------------------------
interface bsa_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bsa_pkg::SIZE_W-1:0]  size_in_use;

    modport source (output valid, output size_in_use, input ready);
    modport sink   (input valid, input size_in_use, output ready);
endinterface

// File: rtl/core/bsa_ram.sv
// ----------------------------------------------------------------------------
// bsa_ram
// Generic simple dual port RAM, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/bitmap_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_unit
// First-free bitmap slot allocator. The slot map lives in a RAM of 64-bit
// words; each request reads map words and writes back any word it changes.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                  | handshake
//  --------+-----+-----------------------------------------+-------------
//  req     | in  | action, slot_index                      | valid/ready
//  rsp     | out | status, result_index, bit_value         | valid/ready
//  cfg     | in  | size_in_use                             | valid/ready
//
//  mark, unmark and test do one RAM read, then a check and, if a slot changes, a write.
//  allocate reads map words in turn until a free slot shows up, at most
//  ceil(size/64) words with size clipped to MAX_SLOTS, and one word when size
//  is zero. after reset a clearing pass writes ceil(MAX_SLOTS/64) words while
//  req.ready stays low; cfg is always ready.
//  the response sits in an output register, so a new request is taken while
//  an earlier response waits; a full output register holds the sequencer.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_unit #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    bsa_req_if.sink     req,
    bsa_rsp_if.source   rsp,
    bsa_cfg_if.sink     cfg
);

    localparam int WORDS  = (MAX_SLOTS + bsa_pkg::WORD_BITS - 1) / bsa_pkg::WORD_BITS;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SPAN_W = $clog2(WORDS * bsa_pkg::WORD_BITS + 1);
    localparam int CMP_W  = (SPAN_W > bsa_pkg::SIZE_W) ? SPAN_W : bsa_pkg::SIZE_W;
    localparam int WB     = bsa_pkg::WORD_BITS;
    localparam int WS     = bsa_pkg::WORD_SHIFT;

    // control and request registers
    bsa_pkg::state_t              state_reg,   state_next;
    bsa_pkg::action_t             act_reg,     act_next;
    logic [bsa_pkg::SLOT_W-1:0]   idx_reg,     idx_next;
    logic [ADDR_W-1:0]            word_reg,    word_next;
    logic [ADDR_W-1:0]            clr_reg,     clr_next;
    logic [bsa_pkg::SIZE_W-1:0]   size_reg;

    // output register
    logic                         out_valid_reg, out_valid_next;
    bsa_pkg::status_t             out_status_reg, out_status_next;
    logic [bsa_pkg::SLOT_W-1:0]   out_index_reg,  out_index_next;
    logic                         out_bit_reg,    out_bit_next;

    // ram ports
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [WB-1:0]                wr_data;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic [WB-1:0]                rd_data;

    // datapath
    logic [CMP_W-1:0]             lim;
    logic [CMP_W-1:0]             base;
    logic [CMP_W-1:0]             base_nxt;
    logic [CMP_W-1:0]             rem;
    logic [CMP_W-1:0]             idx_ext;
    logic [WB-1:0]                range_mask;
    logic [WB-1:0]                free_bits;
    logic [WB-1:0]                one_hot;
    logic [WS-1:0]                free_pos;
    logic                         free_found;
    logic                         more_words;
    logic                         out_free;
    logic                         cur_bit;
    logic [WB-1:0]                idx_bit;
    logic [CMP_W-1:0]             given;

    bsa_ram #(
        .WIDTH (WB),
        .DEPTH (WORDS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // effective slot count, clipped to the map capacity
    always_comb
    begin
        if (CMP_W'(size_reg) > CMP_W'(MAX_SLOTS))
        begin
            lim = CMP_W'(MAX_SLOTS);
        end
        else
        begin
            lim = CMP_W'(size_reg);
        end
    end

    // first free slot inside the current word, below the limit
    always_comb
    begin
        base     = CMP_W'(word_reg) << WS;
        base_nxt = base + CMP_W'(WB);
        rem      = lim - base;
        if (base >= lim)
        begin
            range_mask = '0;
        end
        else if (rem >= CMP_W'(WB))
        begin
            range_mask = '1;
        end
        else
        begin
            range_mask = (WB'(1) << rem[WS-1:0]) - WB'(1);
        end
        free_bits  = ~rd_data & range_mask;
        free_found = |free_bits;
        free_pos   = '0;
        for (int b = WB - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                free_pos = WS'(b);
            end
        end
        one_hot    = WB'(1) << free_pos;
        more_words = base_nxt < lim;
        given      = base | CMP_W'(free_pos);
        idx_ext    = CMP_W'(idx_reg);
        idx_bit    = WB'(1) << idx_reg[WS-1:0];
        cur_bit    = rd_data[idx_reg[WS-1:0]];
    end

    assign out_free = !out_valid_reg || rsp.ready;

    // sequencer: clearing pass, request intake, evaluate and write back
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        idx_next        = idx_reg;
        word_next       = word_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_bit_next    = out_bit_reg;
        wr_en           = 1'b0;
        wr_addr         = word_reg;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = word_reg;
        req.ready       = 1'b0;

        unique case (state_reg)
            bsa_pkg::S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                clr_next = ADDR_W'(clr_reg + 1'b1);
                if (clr_reg == ADDR_W'(WORDS - 1))
                begin
                    clr_next   = '0;
                    state_next = bsa_pkg::S_IDLE;
                end
            end

            bsa_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    act_next = req.action;
                    idx_next = req.slot_index;
                    if (req.action == bsa_pkg::ACT_ALLOC)
                    begin
                        word_next = '0;
                    end
                    else
                    begin
                        word_next = ADDR_W'(CMP_W'(req.slot_index) >> WS);
                    end
                    rd_en      = 1'b1;
                    rd_addr    = word_next;
                    state_next = bsa_pkg::S_EVAL;
                end
            end

            bsa_pkg::S_EVAL:
            begin
                if (act_reg == bsa_pkg::ACT_ALLOC)
                begin
                    if (free_found)
                    begin
                        if (out_free)
                        begin
                            wr_en           = 1'b1;
                            wr_data         = rd_data | one_hot;
                            out_valid_next  = 1'b1;
                            out_status_next = bsa_pkg::ST_OK;
                            out_index_next  = given[bsa_pkg::SLOT_W-1:0];
                            out_bit_next    = 1'b0;
                            state_next      = bsa_pkg::S_IDLE;
                        end
                    end
                    else if (more_words)
                    begin
                        word_next = ADDR_W'(word_reg + 1'b1);
                        rd_en     = 1'b1;
                        rd_addr   = word_next;
                    end
                    else if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = bsa_pkg::ST_FULL;
                        out_index_next  = '0;
                        out_bit_next    = 1'b0;
                        state_next      = bsa_pkg::S_IDLE;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = '0;
                    out_bit_next   = 1'b0;
                    state_next     = bsa_pkg::S_IDLE;
                    if (idx_ext >= lim)
                    begin
                        out_status_next = bsa_pkg::ST_RANGE;
                    end
                    else
                    begin
                        unique case (act_reg)
                            bsa_pkg::ACT_MARK:
                            begin
                                if (cur_bit)
                                begin
                                    out_status_next = bsa_pkg::ST_ISSET;
                                end
                                else
                                begin
                                    out_status_next = bsa_pkg::ST_OK;
                                    wr_en           = 1'b1;
                                    wr_data         = rd_data | idx_bit;
                                end
                            end
                            bsa_pkg::ACT_UNMARK:
                            begin
                                if (!cur_bit)
                                begin
                                    out_status_next = bsa_pkg::ST_ISCLEAR;
                                end
                                else
                                begin
                                    out_status_next = bsa_pkg::ST_OK;
                                    wr_en           = 1'b1;
                                    wr_data         = rd_data & ~idx_bit;
                                end
                            end
                            default:
                            begin
                                out_status_next = bsa_pkg::ST_OK;
                                out_bit_next    = cur_bit;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = bsa_pkg::S_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsa_pkg::S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            size_reg      <= bsa_pkg::SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                size_reg <= cfg.size_in_use;
            end
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        idx_reg        <= idx_next;
        word_reg       <= word_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_bit_reg    <= out_bit_next;
    end

    assign cfg.ready        = 1'b1;
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.result_index = out_index_reg;
    assign rsp.bit_value    = out_bit_reg;

endmodule

// File: rtl/core/bsa_checker.sv
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks of the allocator: response ordering against requests,
// legal status codes and zeroed fields on failure.
// ----------------------------------------------------------------------------
module bsa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [bsa_pkg::STATUS_W-1:0] rsp_status,
    input logic [bsa_pkg::SLOT_W-1:0]  rsp_result_index,
    input logic                        rsp_bit_value
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // requests taken but not yet answered
    always_comb
    begin
        pend_next = pend_reg;
        if (req_acc && !rsp_acc)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!req_acc && rsp_acc)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // no response without an open request, at most two open
    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid |-> pend_reg != 2'd0) && pend_reg != 2'd3)
        else $error("response without open request");

    // status code in range
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= bsa_pkg::ST_ISCLEAR)
        else $error("illegal status code");

    // failed request answers zero index and zero bit
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != bsa_pkg::ST_OK |->
            rsp_result_index == '0 && rsp_bit_value == 1'b0)
        else $error("failed request with nonzero fields");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_result_index) && $stable(rsp_bit_value))
        else $error("stalled response changed");

endmodule

bind bitmap_slot_allocator_unit bsa_checker u_bsa_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_result_index (rsp.result_index),
    .rsp_bit_value    (rsp.bit_value)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap slot allocator. A short directed table
// walks the slot-count extremes, every action and every status code. Random
// request phases follow, each under its own slot count. Every request runs
// through a local model of the slot map, and each response is checked field
// by field against the oldest waiting answer. Both handshake sides stall at
// random, except in one phase that runs with no stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAP_SLOTS    = 4096;
    localparam int IDLE_PERCENT = 22;
    localparam int PHASE_ITEMS  = 95;
    localparam int PLAN_ROWS    = 24;
    localparam int PHASES       = 10;
    localparam int STEADY_PHASE = 3;
    localparam int SLOT_W       = bsa_pkg::SLOT_W;
    localparam int SIZE_W       = bsa_pkg::SIZE_W;

    // one response as the allocator returns it
    typedef struct packed {
        bsa_pkg::status_t    status;
        logic [SLOT_W-1:0]   result_index;
        logic                bit_value;
    } slot_answer_t;

    // directed table row: a slot-count write or a request
    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [SIZE_W-1:0]   size;
        bsa_pkg::action_t    act;
        logic [SLOT_W-1:0]   idx;
        logic                typed;
        slot_answer_t        answer;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    bsa_req_if req_bus ();
    bsa_rsp_if rsp_bus ();
    bsa_cfg_if cfg_bus ();

    bitmap_slot_allocator_unit #(
        .MAX_SLOTS (MAP_SLOTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // local copy of the slot map and the slot count
    bit   [MAP_SLOTS-1:0] slot_bits;
    logic [SIZE_W-1:0]    slot_count;

    slot_answer_t pending_answers [$];
    logic         no_idle;
    int           n_requests;
    int           n_answers;
    int           n_granted;
    int           n_full;
    int           n_cfg;
    int           n_errors;

    // directed requests: extremes, every action, every status code
    plan_row_t plan [0:PLAN_ROWS-1] = '{
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_ALLOC, 12'd0, 1'b1,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_ALLOC, 12'd0, 1'b1,
          '{bsa_pkg::ST_OK, 12'd1, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_TEST, 12'd0, 1'b1,
          '{bsa_pkg::ST_OK, 12'd0, 1'b1}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_TEST, 12'd4095, 1'b1,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_MARK, 12'd4095, 1'b1,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_MARK, 12'd4095, 1'b1,
          '{bsa_pkg::ST_ISSET, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_UNMARK, 12'd4095, 1'b1,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_UNMARK, 12'd4095, 1'b1,
          '{bsa_pkg::ST_ISCLEAR, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_UNMARK, 12'd1, 1'b1,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_ALLOC, 12'd0, 1'b1,
          '{bsa_pkg::ST_OK, 12'd1, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_MARK, 12'd64, 1'b0,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_MARK, 12'd63, 1'b0,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}},
        '{ROW_CFG, 13'd0, bsa_pkg::ACT_ALLOC, 12'd0, 1'b0,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_ALLOC, 12'd0, 1'b1,
          '{bsa_pkg::ST_FULL, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_TEST, 12'd0, 1'b1,
          '{bsa_pkg::ST_RANGE, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_MARK, 12'd0, 1'b1,
          '{bsa_pkg::ST_RANGE, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_UNMARK, 12'd4095, 1'b1,
          '{bsa_pkg::ST_RANGE, 12'd0, 1'b0}},
        '{ROW_CFG, 13'd2, bsa_pkg::ACT_ALLOC, 12'd0, 1'b0,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_ALLOC, 12'd0, 1'b1,
          '{bsa_pkg::ST_FULL, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_TEST, 12'd64, 1'b1,
          '{bsa_pkg::ST_RANGE, 12'd0, 1'b0}},
        '{ROW_CFG, 13'd8191, bsa_pkg::ACT_ALLOC, 12'd0, 1'b0,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_TEST, 12'd64, 1'b1,
          '{bsa_pkg::ST_OK, 12'd0, 1'b1}},
        '{ROW_REQ, 13'd0, bsa_pkg::ACT_ALLOC, 12'd0, 1'b0,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}},
        '{ROW_CFG, 13'd4096, bsa_pkg::ACT_ALLOC, 12'd0, 1'b0,
          '{bsa_pkg::ST_OK, 12'd0, 1'b0}}
    };

    // slot count of each random phase
    logic [SIZE_W-1:0] phase_sizes [0:PHASES-1] = '{
        13'd70, 13'd8191, 13'd1, 13'd300, 13'd0, 13'd4095, 13'd64, 13'd4096, 13'd129, 13'd8
    };

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // slot map model: returns the answer and updates the local map
    function automatic slot_answer_t allocator_answer(input bsa_pkg::action_t act,
                                                      input logic [SLOT_W-1:0] idx);
        int           lim;
        bit           found;
        slot_answer_t ans;
        lim   = (slot_count > MAP_SLOTS) ? MAP_SLOTS : int'(slot_count);
        found = 1'b0;
        ans   = '{bsa_pkg::ST_OK, '0, 1'b0};
        if (act == bsa_pkg::ACT_ALLOC)
        begin
            for (int n = 0; n < lim && !found; n++)
            begin
                if (!slot_bits[n])
                begin
                    slot_bits[n]     = 1'b1;
                    ans.result_index = SLOT_W'(n);
                    found            = 1'b1;
                end
            end
            if (!found)
                ans.status = bsa_pkg::ST_FULL;
        end
        else if (int'(idx) >= lim)
            ans.status = bsa_pkg::ST_RANGE;
        else if (act == bsa_pkg::ACT_MARK)
        begin
            if (slot_bits[idx])
                ans.status = bsa_pkg::ST_ISSET;
            else
                slot_bits[idx] = 1'b1;
        end
        else if (act == bsa_pkg::ACT_UNMARK)
        begin
            if (!slot_bits[idx])
                ans.status = bsa_pkg::ST_ISCLEAR;
            else
                slot_bits[idx] = 1'b0;
        end
        else
            ans.bit_value = slot_bits[idx];
        return ans;
    endfunction

    // present one request, wait for its acceptance, queue its answer
    task automatic issue_request(input bsa_pkg::action_t act,
                                 input logic [SLOT_W-1:0] idx,
                                 input logic typed, input slot_answer_t typed_answer);
        slot_answer_t ans;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.action     <= act;
        req_bus.slot_index <= idx;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        ans = allocator_answer(act, idx);
        pending_answers.push_back(typed ? typed_answer : ans);
        n_requests++;
    endtask

    // write the slot count once every request has been answered
    task automatic write_slot_count(input logic [SIZE_W-1:0] size);
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.size_in_use <= size;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        slot_count = size;
        n_cfg++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // response side stalls
    always @(negedge clk)
        rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // response checker
    always @(posedge clk)
    begin
        slot_answer_t exp_ans;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            n_answers++;
            if (pending_answers.size() == 0)
            begin
                n_errors++;
                $display("%0t: response with no request waiting: status %0d index %0d bit %0d",
                         $time, rsp_bus.status, rsp_bus.result_index, rsp_bus.bit_value);
            end
            else
            begin
                exp_ans = pending_answers.pop_front();
                if (exp_ans.status == bsa_pkg::ST_OK && exp_ans.result_index != 0)
                    n_granted++;
                if (exp_ans.status == bsa_pkg::ST_FULL)
                    n_full++;
                if (rsp_bus.status !== exp_ans.status)
                begin
                    n_errors++;
                    $display("%0t: status expected %0d got %0d",
                             $time, exp_ans.status, rsp_bus.status);
                end
                if (rsp_bus.result_index !== exp_ans.result_index)
                begin
                    n_errors++;
                    $display("%0t: result_index expected %0d got %0d",
                             $time, exp_ans.result_index, rsp_bus.result_index);
                end
                if (rsp_bus.bit_value !== exp_ans.bit_value)
                begin
                    n_errors++;
                    $display("%0t: bit_value expected %0d got %0d",
                             $time, exp_ans.bit_value, rsp_bus.bit_value);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int                lim;
        int                roll;
        int                span;
        bsa_pkg::action_t  act;
        logic [SLOT_W-1:0] idx;

        rst_n               = 1'b0;
        no_idle             = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.action      = bsa_pkg::ACT_ALLOC;
        req_bus.slot_index  = '0;
        rsp_bus.ready       = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.size_in_use = '0;
        slot_bits           = '0;
        slot_count          = bsa_pkg::SIZE_RESET;
        n_requests          = 0;
        n_answers           = 0;
        n_granted           = 0;
        n_full              = 0;
        n_cfg               = 0;
        n_errors            = 0;

        // reset
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].kind == ROW_CFG)
                write_slot_count(plan[r].size);
            else
                issue_request(plan[r].act, plan[r].idx, plan[r].typed, plan[r].answer);
        end

        // random phases, one slot count each
        for (int p = 0; p < PHASES; p++)
        begin
            write_slot_count(phase_sizes[p]);
            no_idle = (p == STEADY_PHASE);
            lim     = (slot_count > MAP_SLOTS) ? MAP_SLOTS : int'(slot_count);
            span    = (lim < 320) ? lim : 320;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // small maps lean on allocate so they fill up and report full
                if ($urandom_range(0, 99) < ((lim <= 300) ? 60 : 30))
                    act = bsa_pkg::ACT_ALLOC;
                else
                    act = bsa_pkg::action_t'($urandom_range(1, 3));
                // mostly the busy low region, some at the size edge, some anywhere
                roll = $urandom_range(0, 99);
                if (lim == 0 || roll < 15)
                    idx = SLOT_W'($urandom_range(0, MAP_SLOTS - 1));
                else if (roll < 25)
                    idx = SLOT_W'(lim - 1 + $urandom_range(0, 1));
                else
                    idx = SLOT_W'($urandom_range(0, span - 1));
                issue_request(act, idx, 1'b0, '{bsa_pkg::ST_OK, '0, 1'b0});
            end
            no_idle = 1'b0;
        end

        // drain
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);

        $display("%0d requests over %0d slot-count writes, %0d responses checked",
                 n_requests, n_cfg, n_answers);
        $display("%0d slots handed out above slot 0, %0d full answers", n_granted, n_full);
        if (n_errors == 0 && pending_answers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // run limit
    initial
    begin
        #12_000_000;
        $display("timeout: %0d responses still waiting", pending_answers.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
